[rtl/fia_pkg.sv]
// shared types and constants of the frame interval averager
`default_nettype none

package fia_pkg;

	localparam int unsigned IV_W      = 32;
	localparam int unsigned RATE_W    = 24;
	localparam int unsigned STAMP_W   = 64;
	localparam int unsigned HELD_W    = 7;
	localparam int unsigned ACC_W     = 33;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};
	localparam logic [IV_W-1:0]   TPS_RESET = 32'd1000;

	typedef enum logic {
		OP_TICK   = 1'b0,
		OP_RESYNC = 1'b1
	} op_t;

	typedef struct packed {
		logic                 operation;
		logic [STAMP_W-1:0]   timestamp;
	} in_beat_t;

	typedef struct packed {
		logic [IV_W-1:0]      average_interval;
		logic [RATE_W-1:0]    frame_rate;
		logic [HELD_W-1:0]    samples_held;
	} out_beat_t;

	// one classified item handed from front to back
	typedef struct packed {
		logic                 is_tick;
		logic [IV_W-1:0]      interval;
		logic [RATE_W-1:0]    rate;
	} fia_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_CHECK,
		BK_DIV,
		BK_DONE
	} back_state_t;

endpackage

`default_nettype wire

[rtl/fia_ram.sv]
// generic single-port ram with registered read
`default_nettype none

module fia_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  wire logic [WIDTH-1:0]                       wdata,
	output      logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

[rtl/fia_front.sv]
// front end: interval measure, frame count and one-second rate latch
`default_nettype none

module fia_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [fia_pkg::IV_W-1:0]    tps,
	input  wire logic                        in_valid,
	output      logic                        in_stall,
	input  wire fia_pkg::in_beat_t           in_beat,
	input  wire fia_pkg::q_stat_t            q_stat,
	output      logic                        push,
	output      fia_pkg::fia_entry_t         push_entry
);

	import fia_pkg::*;

	logic [STAMP_W-1:0] last_stamp_q;
	logic [RATE_W-1:0]  frame_cnt_q;
	logic [ACC_W-1:0]   acc_q;
	logic [RATE_W-1:0]  rate_q;

	logic [STAMP_W-1:0] diff;
	logic [IV_W-1:0]    iv;
	logic [RATE_W-1:0]  frame_inc;
	logic [ACC_W-1:0]   acc_sum;
	logic               latch;
	logic               is_tick;

	assign in_stall = q_stat.full;
	assign push     = in_valid && !q_stat.full;
	assign is_tick  = (in_beat.operation == OP_TICK);

	always_comb begin
		diff      = in_beat.timestamp - last_stamp_q;
		iv        = (|diff[STAMP_W-1:IV_W]) ? {IV_W{1'b1}} : diff[IV_W-1:0];
		frame_inc = (frame_cnt_q == RATE_MAX) ? frame_cnt_q : frame_cnt_q + 1'b1;
		acc_sum   = acc_q + {1'b0, iv};
		latch     = acc_sum > {1'b0, tps};

		push_entry.is_tick  = is_tick;
		push_entry.interval = iv;
		push_entry.rate     = (is_tick && latch) ? frame_inc : rate_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_stamp_q <= '0;
			frame_cnt_q  <= '0;
			acc_q        <= '0;
			rate_q       <= '0;
		end else if (push) begin
			last_stamp_q <= in_beat.timestamp;
			if (is_tick) begin
				if (latch) begin
					rate_q      <= frame_inc;
					frame_cnt_q <= '0;
					acc_q       <= '0;
				end else begin
					frame_cnt_q <= frame_inc;
					acc_q       <= acc_sum;
				end
			end
		end
	end

endmodule

`default_nettype wire

[rtl/fia_queue.sv]
// short fifo between front and back
`default_nettype none

module fia_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire fia_pkg::fia_entry_t   push_entry,
	input  wire logic                  pop,
	output      fia_pkg::fia_entry_t   head,
	output      fia_pkg::q_stat_t      q_stat
);

	import fia_pkg::*;

	localparam int unsigned QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);

	fia_entry_t        slot_q [QUEUE_DEPTH];
	logic [QAW-1:0]    wr_ptr_q;
	logic [QAW-1:0]    rd_ptr_q;
	logic [QCW-1:0]    fill_q;

	function automatic logic [QAW-1:0] ptr_next(input logic [QAW-1:0] p);
		return (p == QAW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign head         = slot_q[rd_ptr_q];
	assign q_stat.full  = (fill_q == QCW'(QUEUE_DEPTH));
	assign q_stat.empty = (fill_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !push || pop)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.empty |-> !pop)
		else $error("queue read while empty");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= QCW'(QUEUE_DEPTH))
		else $error("queue fill out of range");
`endif

endmodule

`default_nettype wire

[rtl/fia_back.sv]
// back end: outlier test, window update, running sum and serial divide
`default_nettype none

module fia_back #(
	parameter int unsigned WINDOW_SIZE = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [fia_pkg::IV_W-1:0]    tps,
	input  wire fia_pkg::fia_entry_t         head,
	input  wire fia_pkg::q_stat_t            q_stat,
	output      logic                        pop,
	output      logic                        out_valid,
	input  wire logic                        out_stall,
	output      fia_pkg::out_beat_t          out_beat
);

	import fia_pkg::*;

	localparam int unsigned CW    = $clog2(WINDOW_SIZE + 1);
	localparam int unsigned AW    = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam int unsigned SUM_W = IV_W + $clog2(WINDOW_SIZE);
	localparam int unsigned DCW   = $clog2(SUM_W + 1);

	back_state_t       state_q, state_d;
	fia_entry_t        item_q;
	logic [CW-1:0]     cnt_q;
	logic [AW-1:0]     wr_ptr_q;
	logic [SUM_W-1:0]  sum_q;
	logic [IV_W-1:0]   mean_q;
	logic [CW-1:0]     rem_q;
	logic [SUM_W-1:0]  dvd_q;
	logic [DCW-1:0]    step_q;
	logic              out_valid_q;
	out_beat_t         out_beat_q;

	logic [IV_W-1:0]   oldest;
	logic              ram_we;
	logic              enter;
	logic              full;
	logic [IV_W:0]     dev_raw;
	logic [IV_W-1:0]   dev;
	logic [SUM_W-1:0]  sum_next;
	logic [CW:0]       trial;
	logic              ge;
	logic [SUM_W-1:0]  quot;
	logic              load_out;
	logic              out_free;
	logic [31:0]       cnt_ext;

	fia_ram #(
		.WIDTH(IV_W),
		.DEPTH(WINDOW_SIZE)
	) u_window (
		.clk   (clk),
		.we    (ram_we),
		.addr  (wr_ptr_q),
		.wdata (item_q.interval),
		.rdata (oldest)
	);

	always_comb begin
		full     = (cnt_q == CW'(WINDOW_SIZE));
		dev_raw  = {1'b0, item_q.interval} - {1'b0, mean_q};
		dev      = dev_raw[IV_W] ? (mean_q - item_q.interval) : dev_raw[IV_W-1:0];
		enter    = item_q.is_tick && (dev < tps);
		sum_next = sum_q + SUM_W'(item_q.interval) - (full ? SUM_W'(oldest) : '0);
		trial    = {rem_q, dvd_q[SUM_W-1]};
		ge       = trial >= {1'b0, cnt_q};
		quot     = {dvd_q[SUM_W-2:0], ge};
		out_free = !out_valid_q || !out_stall;
		cnt_ext  = 32'(cnt_q);
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		ram_we   = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_stat.empty) begin
					pop     = 1'b1;
					state_d = BK_CHECK;
				end
			end
			BK_CHECK: begin
				if (enter) begin
					ram_we  = 1'b1;
					state_d = BK_DIV;
				end else begin
					state_d = BK_DONE;
				end
			end
			BK_DIV: begin
				if (step_q == DCW'(1)) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head;
		end
		if (state_q == BK_CHECK) begin
			rem_q  <= '0;
			dvd_q  <= sum_next;
			step_q <= DCW'(SUM_W);
		end else if (state_q == BK_DIV) begin
			rem_q  <= ge ? CW'(trial - {1'b0, cnt_q}) : CW'(trial);
			dvd_q  <= quot;
			step_q <= step_q - 1'b1;
		end
		if (load_out) begin
			out_beat_q.average_interval <= mean_q;
			out_beat_q.frame_rate       <= item_q.rate;
			out_beat_q.samples_held     <= cnt_ext[HELD_W-1:0];
		end
	end

	// window state and mean
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			wr_ptr_q <= '0;
			sum_q    <= '0;
			mean_q   <= '0;
		end else begin
			if (ram_we) begin
				sum_q    <= sum_next;
				wr_ptr_q <= (wr_ptr_q == AW'(WINDOW_SIZE - 1)) ? '0 : wr_ptr_q + 1'b1;
				if (!full) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (state_q == BK_DIV && step_q == DCW'(1)) begin
				mean_q <= quot[IV_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_beat_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(WINDOW_SIZE))
		else $error("window count beyond window size");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_DIV |-> cnt_q != '0)
		else $error("divide started with empty window");
	a_empty_sum: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> sum_q == '0 && mean_q == '0)
		else $error("empty window holds a sum or mean");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == BK_CHECK)
		else $error("popped item not checked next cycle");
`endif

endmodule

`default_nettype wire

[rtl/frame_interval_averager.sv]
// top level: frame interval averager with frames-per-second counter
//
//  channel   dir  handshake              payload
//  in        in   in_valid / in_stall    in_beat  (operation, timestamp)
//  out       out  out_valid / out_stall  out_beat (average_interval, frame_rate, samples_held)
//  cfg       in   cfg_wr_en              cfg_wr_data (ticks_per_second)
//
// a tick whose interval enters the window passes the back end states check,
// divide and done; the divide state runs the one-bit-per-cycle restoring
// divider over the running sum
// a resync or an outlier tick goes from check straight to done in the back end
// the front takes a beat every cycle while the two-entry queue has room;
// in_stall is high only when that queue is full
// reset clears all control and window state at once; the window ram needs
// no clearing pass since only slots written since reset are ever read
`default_nettype none

module frame_interval_averager #(
	parameter int unsigned WINDOW_SIZE = 64
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [fia_pkg::IV_W-1:0]   cfg_wr_data,
	input  wire logic                       in_valid,
	output      logic                       in_stall,
	input  wire fia_pkg::in_beat_t          in_beat,
	output      logic                       out_valid,
	input  wire logic                       out_stall,
	output      fia_pkg::out_beat_t         out_beat
);

	import fia_pkg::*;

	// ticks per second: outlier threshold and rate window
	logic [IV_W-1:0] tps_q;

	logic        push;
	logic        pop;
	fia_entry_t  push_entry;
	fia_entry_t  head;
	q_stat_t     q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
		end else if (cfg_wr_en) begin
			tps_q <= cfg_wr_data;
		end
	end

	// front: interval, frame count, rate latch
	fia_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.tps        (tps_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_beat    (in_beat),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	// decouples front acceptance from the long divide
	fia_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	// back: window, running sum, mean, result register
	fia_back #(
		.WINDOW_SIZE(WINDOW_SIZE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tps       (tps_q),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_beat  (out_beat)
	);

endmodule

`default_nettype wire
